/* design/cnt_pkg.sv */
// ----------------------------------------------------------------------------
// cnt_pkg
// Shared types and constants for the conditional nesting tracker.
// ----------------------------------------------------------------------------
package cnt_pkg;

   localparam int CNT_MAX_NESTING = 128;

   typedef enum logic [2:0] {
      OP_IF    = 3'd0,
      OP_ELIF  = 3'd1,
      OP_ELSE  = 3'd2,
      OP_ENDIF = 3'd3,
      OP_EOS   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ERR_OK       = 3'd0,
      ERR_NO_IF    = 3'd1,
      ERR_OVERFLOW = 3'd2,
      ERR_NO_ENDIF = 3'd3,
      ERR_LEVEL    = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      BR_NEVER  = 2'd0,
      BR_DONE   = 2'd1,
      BR_TAKING = 2'd2
   } branch_type;

endpackage

/* design/cnt_req_if.sv */
// ----------------------------------------------------------------------------
// cnt_req_if
// Directive channel: one conditional directive per transfer.
// ----------------------------------------------------------------------------
interface cnt_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic       cond_value;
   logic       want_true;

   modport source (output valid, output op, output cond_value, output want_true,
                   input ready);
   modport sink   (input valid, input op, input cond_value, input want_true,
                   output ready);
endinterface

/* design/cnt_rsp_if.sv */
// ----------------------------------------------------------------------------
// cnt_rsp_if
// Result channel: assembly flag, error code and depth per transfer.
// ----------------------------------------------------------------------------
interface cnt_rsp_if;
   logic       valid;
   logic       ready;
   logic       assembling_on;
   logic [2:0] error_code;
   logic [7:0] nesting_depth;

   modport source (output valid, output assembling_on, output error_code,
                   output nesting_depth, input ready);
   modport sink   (input valid, input assembling_on, input error_code,
                   input nesting_depth, output ready);
endinterface

/* design/conditional_nesting_tracker_top.sv */
// ----------------------------------------------------------------------------
// conditional_nesting_tracker_top
// Conditional assembly nesting stack: top entry and skip count in registers,
// lower entries in a memory with the entry below the top prefetched.
//
//   channel   dir  payload
//   req_chan  in   op, cond_value, want_true
//   rsp_chan  out  assembling_on, error_code, nesting_depth
//
// One directive per cycle while no result is held or rsp_chan.ready is high;
// its result is registered and shown in the cycle after the transfer. The
// stack top and the prefetched entry below it let every pop take the new top
// from a register. Reset clears depth, skip count and the result valid; the
// stack memory needs no clearing. A held result stalls input only while rsp_chan.ready is low.
// ----------------------------------------------------------------------------
module conditional_nesting_tracker_top
   import cnt_pkg::*;
#(
   parameter int MAX_NESTING = CNT_MAX_NESTING
) (
   input  logic   clock,
   input  logic   reset,
   cnt_req_if.sink   req_chan,
   cnt_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(MAX_NESTING);
   localparam int DW = $clog2(MAX_NESTING + 1);

   branch_type    mem [2**AW];

   logic [DW-1:0] depth_ff, depth_in;
   logic [DW-1:0] fl_ff, fl_in;
   branch_type    top_ff, top_in;
   branch_type    below_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   err_type       err;
   logic          take;
   logic          accept;
   logic [DW+7:0] depth_wide;

   logic          rsp_valid_ff;
   logic          rsp_on_ff;
   err_type       rsp_err_ff;
   logic [7:0]    rsp_depth_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign take           = req_chan.cond_value == req_chan.want_true;
   assign wr_addr        = AW'(depth_ff - DW'(1));
   assign rd_addr        = AW'(depth_in - DW'(2));
   assign depth_wide     = {8'd0, depth_in};

   always_comb begin
      depth_in = depth_ff;
      fl_in    = fl_ff;
      top_in   = top_ff;
      wr_en    = 1'b0;
      err      = ERR_OK;
      if (accept) begin
         case (req_chan.op)
            OP_IF: begin
               if (depth_ff == DW'(MAX_NESTING)) begin
                  err = ERR_OVERFLOW;
               end else begin
                  wr_en    = depth_ff != '0;
                  depth_in = depth_ff + DW'(1);
                  if (fl_ff == '0 && take) begin
                     top_in = BR_TAKING;
                  end else begin
                     top_in = BR_NEVER;
                     fl_in  = fl_ff + DW'(1);
                  end
               end
            end
            OP_ELIF, OP_ELSE, OP_ENDIF: begin
               if (depth_ff == '0) begin
                  err = ERR_NO_IF;
               end else if (req_chan.op == OP_ENDIF) begin
                  depth_in = depth_ff - DW'(1);
                  top_in   = below_ff;
                  if (top_ff != BR_TAKING && fl_ff != '0) begin
                     fl_in = fl_ff - DW'(1);
                  end
               end else if (req_chan.op == OP_ELIF) begin
                  case (top_ff)
                     BR_NEVER: begin
                        if (fl_ff == DW'(1) && take) begin
                           top_in = BR_TAKING;
                           fl_in  = fl_ff - DW'(1);
                        end
                     end
                     BR_TAKING: begin
                        top_in = BR_DONE;
                        fl_in  = fl_ff + DW'(1);
                     end
                     default: ;
                  endcase
               end else begin
                  case (top_ff)
                     BR_NEVER: begin
                        top_in = BR_TAKING;
                        if (fl_ff != '0) begin
                           fl_in = fl_ff - DW'(1);
                        end
                     end
                     BR_TAKING: begin
                        top_in = BR_NEVER;
                        fl_in  = fl_ff + DW'(1);
                     end
                     default: ;
                  endcase
               end
            end
            OP_EOS: begin
               if (depth_ff != '0) begin
                  err = ERR_NO_ENDIF;
               end else if (fl_ff != '0) begin
                  err = ERR_LEVEL;
               end
            end
            default: ;
         endcase
      end
   end

   // stack memory: lower entries, with the entry under the new top read back
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= top_ff;
      end
      if (wr_en && wr_addr == rd_addr) begin
         below_ff <= top_ff;
      end else begin
         below_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         fl_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         fl_ff    <= fl_in;
         if (req_chan.ready) begin
            rsp_valid_ff <= req_chan.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (accept) begin
         rsp_on_ff    <= fl_in == '0;
         rsp_err_ff   <= err;
         rsp_depth_ff <= depth_wide[7:0];
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.assembling_on = rsp_on_ff;
   assign rsp_chan.error_code    = rsp_err_ff;
   assign rsp_chan.nesting_depth = rsp_depth_ff;

endmodule

/* design/cnt_checker.sv */
// ----------------------------------------------------------------------------
// cnt_checker
// Port-level checks on the conditional nesting tracker.
// ----------------------------------------------------------------------------
module cnt_checker
   import cnt_pkg::*;
#(
   parameter int MAX_NESTING = CNT_MAX_NESTING
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_assembling_on,
   input logic [2:0] rsp_error_code,
   input logic [7:0] rsp_nesting_depth
);

   localparam logic [7:0] MaxLow = 8'(MAX_NESTING);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_error_code)
         && $stable(rsp_nesting_depth) && $stable(rsp_assembling_on))
      else $error("result dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_no_if_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_NO_IF |-> rsp_nesting_depth == 8'd0)
      else $error("missing open if reported with open levels");

   a_overflow_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_OVERFLOW |-> rsp_nesting_depth == MaxLow)
      else $error("overflow reported below full depth");

   a_level_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_LEVEL
         |-> rsp_nesting_depth == 8'd0 && !rsp_assembling_on)
      else $error("level error inconsistent with flag or depth");

endmodule

bind conditional_nesting_tracker_top cnt_checker #(
   .MAX_NESTING (MAX_NESTING)
) u_cnt_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_assembling_on (rsp_chan.assembling_on),
   .rsp_error_code    (rsp_chan.error_code),
   .rsp_nesting_depth (rsp_chan.nesting_depth)
);
